// ----- rtl/core/brf_pkg.sv -----
// Shared codes, widths, defaults and the result record of the byte ring FIFO.
package brf_pkg;

	localparam int FW = 11;
	localparam int CAPACITY_DEF = 1024;
	localparam int MAX_BURST_DEF = 64;

	localparam logic [2:0] OP_RESERVE = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_PEEK    = 3'd2;
	localparam logic [2:0] OP_SKIP    = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_NOROOM = 2'd1;
	localparam logic [1:0] STS_MISUSE = 2'd2;

	typedef struct packed {
		logic [1:0]    status;
		logic [7:0]    data_out;
		logic          data_valid;
		logic [FW-1:0] granted;
		logic [FW-1:0] fill_level;
		logic [FW-1:0] free_space;
		logic          last;
	} res_t;

endpackage

// ----- rtl/core/brf_ram.sv -----
// Byte storage of the ring: one write port and one registered read port.
module brf_ram #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/brf_ctrl.sv -----
// Command decoder, ring counters, reservation tracking and burst read sequencer.
module brf_ctrl #(
	parameter int CAPACITY  = brf_pkg::CAPACITY_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            opcode,
	input  logic [7:0]            data_in,
	input  logic [brf_pkg::FW-1:0] byte_count,
	input  logic                  out_free,
	output logic                  res_load,
	output brf_pkg::res_t         res,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output logic [7:0]            mem_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  logic [7:0]            mem_rdata
);

	localparam int CW = AW + 1;
	localparam int FW = brf_pkg::FW;
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int XW = ((CW > FW) ? CW : FW) + 1;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_BURST = 2'b10
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] head_q, head_d, tail_q, tail_d, cursor_q, cursor_d, base_q, base_d;
	logic [FW-1:0] pend_q, pend_d;
	logic          open_q, open_d;
	logic [BW-1:0] n_q, n_d, iss_q, iss_d, dlv_q, dlv_d;
	logic          rd_vld_s1, rd_vld_d;

	logic [CW-1:0] fill, free, fill_d, rd_sum;
	logic [XW-1:0] cnt_x, fill_x, free_x, take_x, burst_x;
	logic [BW-1:0] burst_n;
	logic          accept, consume, last_byte;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	assign fill    = tail_q - head_q;
	assign free    = CW'(CAPACITY) - fill;
	assign cnt_x   = XW'(byte_count);
	assign fill_x  = XW'(fill);
	assign free_x  = XW'(free);
	assign take_x  = (cnt_x < fill_x) ? cnt_x : fill_x;
	assign burst_x = (take_x > XW'(MAX_BURST)) ? XW'(MAX_BURST) : take_x;
	assign burst_n = BW'(burst_x);

	assign consume   = (state_q == ST_BURST) && rd_vld_s1 && out_free;
	assign last_byte = ((dlv_q + BW'(1)) == n_q);
	assign rd_sum    = base_q + CW'(iss_q);

	assign mem_waddr = cursor_q[AW-1:0];
	assign mem_wdata = data_in;
	assign mem_raddr = rd_sum[AW-1:0];

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cursor_d  = cursor_q;
		pend_d    = pend_q;
		open_d    = open_q;
		base_d    = base_q;
		n_d       = n_q;
		iss_d     = iss_q;
		dlv_d     = dlv_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_load  = 1'b0;
		res       = '0;
		res.last  = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					case (opcode)
						brf_pkg::OP_RESERVE: begin
							if (open_q) begin
								res.status = brf_pkg::STS_MISUSE;
							end else if (cnt_x > free_x) begin
								res.status = brf_pkg::STS_NOROOM;
							end else if (byte_count != '0) begin
								open_d   = 1'b1;
								pend_d   = byte_count;
								cursor_d = tail_q;
							end
						end
						brf_pkg::OP_WRITE: begin
							if (!open_q) begin
								res.status = brf_pkg::STS_MISUSE;
							end else begin
								mem_we   = 1'b1;
								cursor_d = cursor_q + CW'(1);
								pend_d   = pend_q - FW'(1);
								if (pend_q == FW'(1)) begin
									tail_d = cursor_q + CW'(1);
									open_d = 1'b0;
								end
							end
						end
						brf_pkg::OP_SKIP: begin
							head_d      = head_q + CW'(take_x);
							res.granted = FW'(take_x);
						end
						brf_pkg::OP_PEEK, brf_pkg::OP_READ: begin
							if (burst_n != '0) begin
								res_load = 1'b0;
								state_d  = ST_BURST;
								base_d   = head_q;
								n_d      = burst_n;
								iss_d    = '0;
								dlv_d    = '0;
								if (opcode == brf_pkg::OP_READ) begin
									head_d = head_q + CW'(burst_n);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_BURST: begin
				if (consume) begin
					res_load       = 1'b1;
					res.data_out   = mem_rdata;
					res.data_valid = 1'b1;
					res.granted    = FW'(n_q);
					res.last       = last_byte;
					dlv_d          = dlv_q + BW'(1);
					if (last_byte) begin
						state_d = ST_IDLE;
					end
				end
				if ((iss_q != n_q) && (!rd_vld_s1 || out_free)) begin
					mem_re = 1'b1;
					iss_d  = iss_q + BW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		fill_d         = tail_d - head_d;
		res.fill_level = FW'(fill_d);
		res.free_space = FW'(CW'(CAPACITY) - fill_d);
		rd_vld_d       = mem_re || (rd_vld_s1 && !consume);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			cursor_q  <= '0;
			pend_q    <= '0;
			open_q    <= 1'b0;
			n_q       <= '0;
			iss_q     <= '0;
			dlv_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			cursor_q  <= cursor_d;
			pend_q    <= pend_d;
			open_q    <= open_d;
			n_q       <= n_d;
			iss_q     <= iss_d;
			dlv_q     <= dlv_d;
			rd_vld_s1 <= rd_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
	end

endmodule

// ----- rtl/core/byte_ring_fifo_atomic_write_core.sv -----
// Top level of the byte ring FIFO with reserved writes: storage, control and result register.
// Single-result commands: result registered and valid in the cycle after acceptance, one
// item per cycle while the output is not stalled. Peek and read of n bytes: the control
// enters its burst state; bytes go from the registered read port to the result register, one
// byte per cycle while the output is free (single read port); the next item waits for idle.
// Reset clears the counters, the reservation and the result valid flag; storage is not cleared.
module byte_ring_fifo_atomic_write_core #(
	parameter int CAPACITY  = brf_pkg::CAPACITY_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0]             opcode,
	input  logic [7:0]             data_in,
	input  logic [brf_pkg::FW-1:0] byte_count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [7:0]             data_out,
	output logic                   data_valid,
	output logic [brf_pkg::FW-1:0] granted,
	output logic [brf_pkg::FW-1:0] fill_level,
	output logic [brf_pkg::FW-1:0] free_space,
	output logic                   last
);

	localparam int AW = $clog2(CAPACITY);

	logic          out_valid_q;
	brf_pkg::res_t res_q, res;
	logic          res_load, out_free;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	assign out_free = !out_valid_q || out_ready;

	brf_ctrl #(
		.CAPACITY (CAPACITY),
		.MAX_BURST(MAX_BURST)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.data_in   (data_in),
		.byte_count(byte_count),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	brf_ram #(
		.AW(AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_q.status;
	assign data_out   = res_q.data_out;
	assign data_valid = res_q.data_valid;
	assign granted    = res_q.granted;
	assign fill_level = res_q.fill_level;
	assign free_space = res_q.free_space;
	assign last       = res_q.last;

endmodule

// ----- tb/byte_ring_fifo_atomic_write_core_test.sv -----
// Self-checking testbench for the byte ring FIFO with reserved writes, peek, skip and read.
`timescale 1ns / 1ps

module byte_ring_fifo_atomic_write_core_test;

	localparam int FW = brf_pkg::FW;
	localparam int RING_BYTES = brf_pkg::CAPACITY_DEF;
	localparam int BURST = brf_pkg::MAX_BURST_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = brf_pkg::OP_PEEK;
	logic [7:0] data_in = 8'd0;
	logic [FW-1:0] byte_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [7:0] data_out;
	logic data_valid;
	logic [FW-1:0] granted;
	logic [FW-1:0] fill_level;
	logic [FW-1:0] free_space;
	logic last;

	// Shadow copy of the ring and its counters.
	logic [7:0] ring_mem [RING_BYTES];
	logic [FW-1:0] head_cnt = '0;
	logic [FW-1:0] tail_cnt = '0;
	logic [FW-1:0] cursor = '0;
	logic [FW-1:0] bytes_owed = '0;
	logic msg_open = 1'b0;

	brf_pkg::res_t fifo_replies [$];
	int errors = 0;
	int items_sent = 0;
	int cycle_count = 0;

	byte_ring_fifo_atomic_write_core #(
		.CAPACITY(RING_BYTES),
		.MAX_BURST(BURST)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.data_in(data_in),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.data_out(data_out),
		.data_valid(data_valid),
		.granted(granted),
		.fill_level(fill_level),
		.free_space(free_space),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [FW-1:0] ring_fill();
		return tail_cnt - head_cnt;
	endfunction

	task automatic push_reply(logic [1:0] st, logic [7:0] b, logic v, logic [FW-1:0] g,
			logic l);
		brf_pkg::res_t r;
		logic [FW-1:0] f;
		f = ring_fill();
		r.status = st;
		r.data_out = b;
		r.data_valid = v;
		r.granted = g;
		r.fill_level = f;
		r.free_space = FW'(RING_BYTES) - f;
		r.last = l;
		fifo_replies.push_back(r);
	endtask

	task automatic predict_command(logic [2:0] op, logic [7:0] d, logic [FW-1:0] cnt);
		logic [FW-1:0] avail;
		logic [FW-1:0] n;
		logic [7:0] burst [$];
		avail = ring_fill();
		case (op)
			brf_pkg::OP_RESERVE: begin
				if (msg_open) begin
					push_reply(brf_pkg::STS_MISUSE, 8'd0, 1'b0, '0, 1'b1);
				end else if (cnt > FW'(RING_BYTES) - avail) begin
					push_reply(brf_pkg::STS_NOROOM, 8'd0, 1'b0, '0, 1'b1);
				end else begin
					if (cnt != 0) begin
						msg_open = 1'b1;
						bytes_owed = cnt;
						cursor = tail_cnt;
					end
					push_reply(brf_pkg::STS_OK, 8'd0, 1'b0, '0, 1'b1);
				end
			end
			brf_pkg::OP_WRITE: begin
				if (!msg_open) begin
					push_reply(brf_pkg::STS_MISUSE, 8'd0, 1'b0, '0, 1'b1);
				end else begin
					ring_mem[int'(cursor) % RING_BYTES] = d;
					cursor = cursor + 1'b1;
					bytes_owed = bytes_owed - 1'b1;
					if (bytes_owed == 0) begin
						tail_cnt = cursor;
						msg_open = 1'b0;
					end
					push_reply(brf_pkg::STS_OK, 8'd0, 1'b0, '0, 1'b1);
				end
			end
			brf_pkg::OP_SKIP: begin
				n = (cnt < avail) ? cnt : avail;
				head_cnt = head_cnt + n;
				push_reply(brf_pkg::STS_OK, 8'd0, 1'b0, n, 1'b1);
			end
			brf_pkg::OP_PEEK, brf_pkg::OP_READ: begin
				n = (cnt < avail) ? cnt : avail;
				if (n > FW'(BURST))
					n = FW'(BURST);
				if (n == 0) begin
					push_reply(brf_pkg::STS_OK, 8'd0, 1'b0, '0, 1'b1);
				end else begin
					for (int i = 0; i < int'(n); i++)
						burst.push_back(ring_mem[(int'(head_cnt) + i) % RING_BYTES]);
					if (op == brf_pkg::OP_READ)
						head_cnt = head_cnt + n;
					for (int i = 0; i < int'(n); i++)
						push_reply(brf_pkg::STS_OK, burst[i], 1'b1, n, i == int'(n) - 1);
				end
			end
			default: push_reply(brf_pkg::STS_OK, 8'd0, 1'b0, '0, 1'b1);
		endcase
	endtask

	// Called at a rising edge; returns at the rising edge where the item is taken.
	task automatic send_item(logic [2:0] op, logic [7:0] d, logic [FW-1:0] cnt);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_in <= d;
		byte_count <= cnt;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		predict_command(op, d, cnt);
		items_sent++;
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [FW-1:0] any_count();
		return FW'($urandom_range(0, RING_BYTES));
	endfunction

	task automatic check_field(string name, int expected, int actual);
		if (expected !== actual) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
			errors++;
		end
	endtask

	initial begin
		brf_pkg::res_t want;
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (out_valid !== 1'b1);
			if (fifo_replies.size() == 0) begin
				$display("%0t: no result expected, got status %0d data %0d granted %0d",
					$time, status, data_out, granted);
				errors++;
			end else begin
				want = fifo_replies.pop_front();
				check_field("status", want.status, status);
				check_field("data_out", want.data_out, data_out);
				check_field("data_valid", want.data_valid, data_valid);
				check_field("granted", want.granted, granted);
				check_field("fill_level", want.fill_level, fill_level);
				check_field("free_space", want.free_space, free_space);
				check_field("last", want.last, last);
			end
			@(posedge clk);
		end
	end

	task automatic test_directed_cases();
		send_item(brf_pkg::OP_READ, any_byte(), '0);
		send_item(brf_pkg::OP_PEEK, any_byte(), FW'(RING_BYTES));
		send_item(brf_pkg::OP_SKIP, any_byte(), FW'(RING_BYTES));
		send_item(brf_pkg::OP_WRITE, 8'hFF, any_count());
		send_item(brf_pkg::OP_RESERVE, any_byte(), '0);
		send_item(brf_pkg::OP_RESERVE, any_byte(), FW'(2));
		send_item(brf_pkg::OP_RESERVE, any_byte(), FW'(5));
		send_item(brf_pkg::OP_WRITE, 8'h00, any_count());
		send_item(brf_pkg::OP_WRITE, 8'hFF, any_count());
		send_item(brf_pkg::OP_RESERVE, any_byte(), FW'(RING_BYTES));
		send_item(brf_pkg::OP_PEEK, any_byte(), FW'(RING_BYTES));
		send_item(brf_pkg::OP_READ, any_byte(), FW'(1));
		send_item(brf_pkg::OP_SKIP, any_byte(), FW'(RING_BYTES));
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			send_item(3'(op), any_byte(), any_count());
		send_item(brf_pkg::OP_RESERVE, any_byte(), FW'(1));
		send_item(brf_pkg::OP_WRITE, 8'h5A, any_count());
		send_item(brf_pkg::OP_PEEK, any_byte(), '0);
		send_item(brf_pkg::OP_READ, any_byte(), FW'(RING_BYTES));
	endtask

	task automatic send_message(logic [FW-1:0] len);
		send_item(brf_pkg::OP_RESERVE, any_byte(), len);
		while (msg_open) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: send_item(brf_pkg::OP_READ, any_byte(), FW'($urandom_range(0, 16)));
					1: send_item(brf_pkg::OP_PEEK, any_byte(), FW'($urandom_range(0, 16)));
					2: send_item(brf_pkg::OP_SKIP, any_byte(), FW'($urandom_range(0, 8)));
					default: send_item(brf_pkg::OP_RESERVE, any_byte(), any_count());
				endcase
			end
			send_item(brf_pkg::OP_WRITE, any_byte(), any_count());
		end
	endtask

	function automatic logic [FW-1:0] burst_count();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return FW'($urandom_range(0, 16));
		else if (pick < 9)
			return FW'($urandom_range(17, 80));
		return ($urandom_range(0, 1) == 0) ? FW'(RING_BYTES) : any_count();
	endfunction

	task automatic test_random_traffic(int n_items);
		int stop_at;
		int pick;
		int len_pick;
		logic [FW-1:0] room;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			room = FW'(RING_BYTES) - ring_fill();
			if (pick <= 8) begin
				len_pick = $urandom_range(0, 9);
				if (len_pick == 0)
					send_message('0);
				else if (len_pick == 1)
					send_message(FW'($urandom_range(9, 64)));
				else
					send_message(FW'($urandom_range(1, 8)));
			end else if (pick <= 12) begin
				send_item(brf_pkg::OP_READ, any_byte(), burst_count());
			end else if (pick <= 14) begin
				send_item(brf_pkg::OP_PEEK, any_byte(), burst_count());
			end else if (pick <= 16) begin
				send_item(brf_pkg::OP_SKIP, any_byte(),
					($urandom_range(0, 7) == 0) ? any_count() : FW'($urandom_range(0, 24)));
			end else if (pick == 17) begin
				send_item(brf_pkg::OP_WRITE, any_byte(), any_count());
			end else if (pick == 18) begin
				send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), any_byte(),
					any_count());
			end else if (room < FW'(RING_BYTES)) begin
				send_item(brf_pkg::OP_RESERVE, any_byte(),
					FW'($urandom_range(int'(room) + 1, RING_BYTES)));
			end else begin
				send_item(brf_pkg::OP_READ, any_byte(), burst_count());
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_traffic(330);
		in_valid <= 1'b0;
		while (fifo_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
